[rtl/ipv4_two_port_forwarder_unit_assert.svh]
// assertion macros for the ipv4 two-port forwarder
// needs a clk and an active-low rst_n in the including module
`ifndef IPV4_TWO_PORT_FORWARDER_UNIT_ASSERT_SVH
`define IPV4_TWO_PORT_FORWARDER_UNIT_ASSERT_SVH

`ifndef NO_ASSERTIONS
`define FWD_ASSERT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);
`define FWD_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);
`else
`define FWD_ASSERT(lbl, ante, cons, msg)
`define FWD_ASSERT_NEXT(lbl, ante, cons, msg)
`endif

`endif

[rtl/ipv4fw_pkg.sv]
// types and constants for the ipv4 two-port forwarder
// used by ipv4fw_route, the top level and the testbench
package ipv4fw_pkg;

  localparam logic [15:0] ETYPE_IPV4 = 16'h0800;
  localparam int          CFG_IDX_W  = 3;
  localparam int          CFG_DATA_W = 48;

  typedef enum logic [3:0] {
    VERD_FWD       = 4'd0,
    VERD_LOCAL     = 4'd1,
    VERD_NOT_IPV4  = 4'd2,
    VERD_BAD_IN    = 4'd3,
    VERD_WRONG_MAC = 4'd4,
    VERD_TTL       = 4'd5,
    VERD_NO_ROUTE  = 4'd6,
    VERD_SAME_PORT = 4'd7,
    VERD_NO_NEIGH  = 4'd8,
    VERD_STORED    = 4'd9,
    VERD_FULL      = 4'd10
  } verdict_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_PORT0_MAC    = 3'd0,
    CFG_PORT0_IP     = 3'd1,
    CFG_PORT0_PREFIX = 3'd2,
    CFG_PORT1_MAC    = 3'd3,
    CFG_PORT1_IP     = 3'd4,
    CFG_PORT1_PREFIX = 3'd5
  } cfg_idx_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_CHECK,
    S_SCAN,
    S_OUT
  } fwd_state_t;

  // header check outcome
  typedef struct packed {
    logic     done;
    verdict_t verdict;
    logic     egress;
  } route_res_t;

endpackage

[rtl/ipv4fw_nbr_mem.sv]
// neighbour table storage: ip and mac arrays, one write and one read port
// read data registered, valid the cycle after the address; depends on nothing
module ipv4fw_nbr_mem #(
  parameter int DEPTH = 16,
  parameter int AW    = 4
) (
  input  logic          clk,
  input  logic          we,
  input  logic [AW-1:0] waddr,
  input  logic [31:0]   wip,
  input  logic [47:0]   wmac,
  input  logic [AW-1:0] raddr,
  output logic [31:0]   rip,
  output logic [47:0]   rmac
);

  logic [31:0] ip_mem  [DEPTH];
  logic [47:0] mac_mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      ip_mem[waddr]  <= wip;
      mac_mem[waddr] <= wmac;
    end
  end

  always_ff @(posedge clk) begin
    rip  <= ip_mem[raddr];
    rmac <= mac_mem[raddr];
  end

endmodule

[rtl/ipv4fw_route.sv]
// frame header checks and connected-route selection
// depends on ipv4fw_pkg
module ipv4fw_route import ipv4fw_pkg::*; (
  input  logic [15:0] frame_type,
  input  logic [1:0]  ingress_port,
  input  logic [47:0] frame_dst_mac,
  input  logic [31:0] dest_ip,
  input  logic [7:0]  hop_limit,
  input  logic [47:0] port0_mac,
  input  logic [31:0] port0_ip,
  input  logic [5:0]  port0_prefix,
  input  logic [47:0] port1_mac,
  input  logic [31:0] port1_ip,
  input  logic [5:0]  port1_prefix,
  output route_res_t  res
);

  logic [31:0] mask0, mask1;
  logic [5:0]  len0, len1;
  logic        hit0, hit1, route_ok, route_port;

  function automatic logic [31:0] pfx_mask(input logic [5:0] p);
    logic [31:0] m;
    if (p == 6'd0) begin
      m = 32'd0;
    end else if (p >= 6'd32) begin
      m = 32'hFFFF_FFFF;
    end else begin
      m = ~(32'hFFFF_FFFF >> p);
    end
    return m;
  endfunction

  always_comb begin
    mask0 = pfx_mask(port0_prefix);
    mask1 = pfx_mask(port1_prefix);
    len0  = (port0_prefix > 6'd32) ? 6'd32 : port0_prefix;
    len1  = (port1_prefix > 6'd32) ? 6'd32 : port1_prefix;
    hit0  = (dest_ip & mask0) == (port0_ip & mask0);
    hit1  = (dest_ip & mask1) == (port1_ip & mask1);
    route_ok   = hit0 || hit1;
    route_port = hit1 && (!hit0 || (len1 > len0));

    res.done    = 1'b1;
    res.verdict = VERD_FWD;
    res.egress  = route_port;
    if (frame_type != ETYPE_IPV4) begin
      res.verdict = VERD_NOT_IPV4;
    end else if (ingress_port > 2'd1) begin
      res.verdict = VERD_BAD_IN;
    end else if (frame_dst_mac != (ingress_port[0] ? port1_mac : port0_mac)) begin
      res.verdict = VERD_WRONG_MAC;
    end else if (dest_ip == port0_ip || dest_ip == port1_ip) begin
      res.verdict = VERD_LOCAL;
    end else if (hop_limit <= 8'd1) begin
      res.verdict = VERD_TTL;
    end else if (!route_ok) begin
      res.verdict = VERD_NO_ROUTE;
    end else if (route_port == ingress_port[0]) begin
      res.verdict = VERD_SAME_PORT;
    end else begin
      // needs the neighbour lookup
      res.done = 1'b0;
    end
  end

endmodule

[rtl/ipv4_two_port_forwarder_unit.sv]
// a beat taken in idle goes through the check state and the output state, which loads
// the result once the output registers are free; neighbour updates and undecided frames
// pass the scan state in between, one entry per cycle through the single table read port
// throughput: one item at a time; the next beat is taken once the result is registered
// reset clears the config registers, the entry count, the state and the valid flags; the table memory
// is not cleared, entries at or above the count are never read
// top level of the ipv4 two-port forwarder; depends on ipv4fw_pkg, ipv4fw_route,
// ipv4fw_nbr_mem and ipv4_two_port_forwarder_unit_assert.svh
`include "ipv4_two_port_forwarder_unit_assert.svh"

module ipv4_two_port_forwarder_unit import ipv4fw_pkg::*; #(
  parameter int NEIGHBOUR_ENTRIES = 16
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_addr,
  input  logic [CFG_DATA_W-1:0] cfg_wdata,
  input  logic                  in_tvalid,
  output logic                  in_tready,
  // frame_type, ingress_port, frame_dst_mac, dest_ip, hop_limit, entry_ip, entry_mac
  input  logic [191:0]          in_tdata,
  // action
  input  logic                  in_tuser,
  output logic                  out_tvalid,
  input  logic                  out_tready,
  // egress_port, new_dst_mac, new_src_mac, new_hop_limit
  output logic [111:0]          out_tdata,
  // verdict
  output logic [3:0]            out_tuser
);

  localparam int CW = $clog2(NEIGHBOUR_ENTRIES + 1);
  localparam int IW = (NEIGHBOUR_ENTRIES > 1) ? $clog2(NEIGHBOUR_ENTRIES) : 1;
  localparam logic [CW-1:0] FULL_CNT = CW'(NEIGHBOUR_ENTRIES);

  // config
  logic [47:0] p0_mac_r, p1_mac_r;
  logic [31:0] p0_ip_r, p1_ip_r;
  logic [5:0]  p0_pfx_r, p1_pfx_r;

  // captured item
  logic        action_r;
  logic [15:0] etype_r;
  logic [1:0]  inport_r;
  logic [47:0] dmac_r;
  logic [31:0] dip_r;
  logic [7:0]  ttl_r;
  logic [31:0] eip_r;
  logic [47:0] emac_r;

  fwd_state_t    state_r, state_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic [CW-1:0] rd_idx_r, rd_idx_nxt;
  logic          chk_vld_r, chk_vld_nxt;
  logic [IW-1:0] chk_idx_r, chk_idx_nxt;

  verdict_t    res_verdict_r, res_verdict_nxt;
  logic        res_egress_r, res_egress_nxt;
  logic [47:0] res_dst_r, res_dst_nxt;
  logic [47:0] res_src_r, res_src_nxt;
  logic [7:0]  res_ttl_r, res_ttl_nxt;

  logic        out_vld_r, out_vld_nxt;
  logic        out_load;
  verdict_t    out_verdict_r;
  logic        out_egress_r;
  logic [47:0] out_dst_r, out_src_r;
  logic [7:0]  out_ttl_r;

  route_res_t    rt;
  logic [31:0]   key;
  logic          issue_ok;
  logic          mem_we;
  logic [IW-1:0] mem_waddr;
  logic [31:0]   rd_ip;
  logic [47:0]   rd_mac;

  assign in_tready  = (state_r == S_IDLE);
  assign out_tvalid = out_vld_r;
  assign out_tuser  = out_verdict_r;
  assign out_tdata  = {7'd0, out_ttl_r, out_src_r, out_dst_r, out_egress_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      p0_mac_r <= '0;
      p0_ip_r  <= '0;
      p0_pfx_r <= '0;
      p1_mac_r <= '0;
      p1_ip_r  <= '0;
      p1_pfx_r <= '0;
    end else if (cfg_we) begin
      case (cfg_addr)
        CFG_PORT0_MAC:    p0_mac_r <= cfg_wdata[47:0];
        CFG_PORT0_IP:     p0_ip_r  <= cfg_wdata[31:0];
        CFG_PORT0_PREFIX: p0_pfx_r <= cfg_wdata[5:0];
        CFG_PORT1_MAC:    p1_mac_r <= cfg_wdata[47:0];
        CFG_PORT1_IP:     p1_ip_r  <= cfg_wdata[31:0];
        CFG_PORT1_PREFIX: p1_pfx_r <= cfg_wdata[5:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (in_tvalid && in_tready) begin
      action_r <= in_tuser;
      etype_r  <= in_tdata[15:0];
      inport_r <= in_tdata[17:16];
      dmac_r   <= in_tdata[65:18];
      dip_r    <= in_tdata[97:66];
      ttl_r    <= in_tdata[105:98];
      eip_r    <= in_tdata[137:106];
      emac_r   <= in_tdata[185:138];
    end
  end

  ipv4fw_route u_route (
    .frame_type    (etype_r),
    .ingress_port  (inport_r),
    .frame_dst_mac (dmac_r),
    .dest_ip       (dip_r),
    .hop_limit     (ttl_r),
    .port0_mac     (p0_mac_r),
    .port0_ip      (p0_ip_r),
    .port0_prefix  (p0_pfx_r),
    .port1_mac     (p1_mac_r),
    .port1_ip      (p1_ip_r),
    .port1_prefix  (p1_pfx_r),
    .res           (rt)
  );

  ipv4fw_nbr_mem #(
    .DEPTH (NEIGHBOUR_ENTRIES),
    .AW    (IW)
  ) u_mem (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wip   (key),
    .wmac  (emac_r),
    .raddr (rd_idx_r[IW-1:0]),
    .rip   (rd_ip),
    .rmac  (rd_mac)
  );

  assign key      = action_r ? eip_r : dip_r;
  assign issue_ok = rd_idx_r < cnt_r;

  always_comb begin
    state_nxt       = state_r;
    cnt_nxt         = cnt_r;
    rd_idx_nxt      = rd_idx_r;
    chk_vld_nxt     = 1'b0;
    chk_idx_nxt     = rd_idx_r[IW-1:0];
    res_verdict_nxt = res_verdict_r;
    res_egress_nxt  = res_egress_r;
    res_dst_nxt     = res_dst_r;
    res_src_nxt     = res_src_r;
    res_ttl_nxt     = res_ttl_r;
    mem_we          = 1'b0;
    mem_waddr       = chk_idx_r;
    out_load        = 1'b0;

    case (state_r)
      S_IDLE: begin
        if (in_tvalid) begin
          state_nxt = S_CHECK;
        end
      end
      S_CHECK: begin
        rd_idx_nxt      = '0;
        res_verdict_nxt = rt.verdict;
        res_egress_nxt  = 1'b0;
        res_dst_nxt     = '0;
        res_src_nxt     = '0;
        res_ttl_nxt     = ttl_r;
        if (!action_r && rt.done) begin
          state_nxt = S_OUT;
        end else begin
          state_nxt = S_SCAN;
        end
      end
      S_SCAN: begin
        if (chk_vld_r && rd_ip == key) begin
          state_nxt = S_OUT;
          if (action_r) begin
            // update the mac of a known neighbour
            mem_we          = 1'b1;
            res_verdict_nxt = VERD_STORED;
          end else begin
            res_verdict_nxt = VERD_FWD;
            res_egress_nxt  = rt.egress;
            res_dst_nxt     = rd_mac;
            res_src_nxt     = rt.egress ? p1_mac_r : p0_mac_r;
            res_ttl_nxt     = ttl_r - 8'd1;
          end
        end else if (!chk_vld_r && !issue_ok) begin
          state_nxt = S_OUT;
          if (!action_r) begin
            res_verdict_nxt = VERD_NO_NEIGH;
          end else if (cnt_r == FULL_CNT) begin
            res_verdict_nxt = VERD_FULL;
          end else begin
            mem_we          = 1'b1;
            mem_waddr       = cnt_r[IW-1:0];
            cnt_nxt         = cnt_r + CW'(1);
            res_verdict_nxt = VERD_STORED;
          end
        end else if (issue_ok) begin
          chk_vld_nxt = 1'b1;
          rd_idx_nxt  = rd_idx_r + CW'(1);
        end
      end
      S_OUT: begin
        if (!out_vld_r || out_tready) begin
          out_load  = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase

    out_vld_nxt = out_load || (out_vld_r && !out_tready);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= S_IDLE;
      cnt_r     <= '0;
      chk_vld_r <= 1'b0;
      out_vld_r <= 1'b0;
    end else begin
      state_r   <= state_nxt;
      cnt_r     <= cnt_nxt;
      chk_vld_r <= chk_vld_nxt;
      out_vld_r <= out_vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    rd_idx_r      <= rd_idx_nxt;
    chk_idx_r     <= chk_idx_nxt;
    res_verdict_r <= res_verdict_nxt;
    res_egress_r  <= res_egress_nxt;
    res_dst_r     <= res_dst_nxt;
    res_src_r     <= res_src_nxt;
    res_ttl_r     <= res_ttl_nxt;
    if (out_load) begin
      out_verdict_r <= res_verdict_r;
      out_egress_r  <= res_egress_r;
      out_dst_r     <= res_dst_r;
      out_src_r     <= res_src_r;
      out_ttl_r     <= res_ttl_r;
    end
  end

  `FWD_ASSERT(a_cnt_bound, 1'b1, cnt_r <= FULL_CNT, "neighbour count above table size")
  `FWD_ASSERT(a_chk_in_range, chk_vld_r, CW'(chk_idx_r) < cnt_r, "scan read past count")
  `FWD_ASSERT_NEXT(a_cnt_only_on_write, !mem_we, $stable(cnt_r), "count moved without write")
  `FWD_ASSERT(a_write_in_scan, mem_we, state_r == S_SCAN, "table write outside scan")
  `FWD_ASSERT(a_fwd_ttl, out_vld_r && out_verdict_r == VERD_FWD, out_ttl_r != 8'd0,
              "forwarded beat with zero ttl")

endmodule

[dv/tb_ipv4_two_port_forwarder_unit.sv]
// self-checking testbench for ipv4_two_port_forwarder_unit: directed header, route and
// neighbour table cases, then random beats in four port settings, three with stalls
// depends on ipv4fw_pkg and the rtl of the forwarder
module tb_ipv4_two_port_forwarder_unit;
  import ipv4fw_pkg::*;

  localparam int NEIGHBOUR_ENTRIES = 16;
  localparam int IDLE_LIMIT = 2000;
  localparam int ROUTE_NONE = 2;
  localparam logic [CFG_IDX_W-1:0] CFG_IDX_SPARE_LO = 3'd6;
  localparam logic [CFG_IDX_W-1:0] CFG_IDX_SPARE_HI = 3'd7;

  typedef struct packed {
    logic        action;
    logic [15:0] frame_type;
    logic [1:0]  ingress;
    logic [47:0] dst_mac;
    logic [31:0] dest_ip;
    logic [7:0]  ttl;
    logic [31:0] entry_ip;
    logic [47:0] entry_mac;
  } fwd_item_t;

  typedef struct packed {
    verdict_t    verdict;
    logic        egress;
    logic [47:0] dst_mac;
    logic [47:0] src_mac;
    logic [7:0]  hop;
  } fwd_result_t;

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_addr = '0;
  logic [CFG_DATA_W-1:0] cfg_wdata = '0;
  logic                  in_tvalid = 1'b0;
  logic                  in_tready;
  logic [191:0]          in_tdata = '0;
  logic                  in_tuser = 1'b0;
  logic                  out_tvalid;
  logic                  out_tready = 1'b0;
  logic [111:0]          out_tdata;
  logic [3:0]            out_tuser;

  // port settings and neighbour table as the block should hold them
  logic [47:0] port_mac [2];
  logic [31:0] port_ip [2];
  logic [5:0]  port_pfx [2];
  logic [31:0] nbr_ip [NEIGHBOUR_ENTRIES];
  logic [47:0] nbr_mac [NEIGHBOUR_ENTRIES];
  int          nbr_count = 0;

  fwd_result_t pending_q [$];
  int errors = 0;
  int beats_sent = 0;
  int results_seen = 0;
  int fwd_seen = 0;
  int cfg_writes = 0;
  int idle_cycles = 0;
  int rx_hold = 0;
  bit no_idle = 1'b0;

  ipv4_two_port_forwarder_unit #(
    .NEIGHBOUR_ENTRIES(NEIGHBOUR_ENTRIES)
  ) i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_addr  (cfg_addr),
    .cfg_wdata (cfg_wdata),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .out_tuser (out_tuser)
  );

  always #1 clk = ~clk;

  function automatic logic [47:0] rand48();
    return {16'($urandom), 32'($urandom)};
  endfunction

  function automatic int gap_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    if (r < 98) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  function automatic logic [31:0] subnet_mask(input logic [5:0] p);
    int n;
    n = (p > 32) ? 32 : p;
    if (n == 0) return '0;
    return 32'hFFFF_FFFF << (32 - n);
  endfunction

  function automatic bit find_nbr(input logic [31:0] ip, output int idx);
    idx = 0;
    for (int i = 0; i < nbr_count; i++) begin
      if (nbr_ip[i] == ip) begin
        idx = i;
        return 1'b1;
      end
    end
    return 1'b0;
  endfunction

  // forwarding decision plus neighbour table update for one accepted beat
  function automatic fwd_result_t forward_decision(input fwd_item_t it);
    fwd_result_t r;
    int          idx;
    int          route;
    logic [31:0] m0, m1;
    bit          hit0, hit1;
    int          l0, l1;
    r.verdict = VERD_FWD;
    r.egress = 1'b0;
    r.dst_mac = '0;
    r.src_mac = '0;
    r.hop = it.ttl;
    if (it.action) begin
      if (find_nbr(it.entry_ip, idx)) begin
        nbr_mac[idx] = it.entry_mac;
        r.verdict = VERD_STORED;
      end else if (nbr_count >= NEIGHBOUR_ENTRIES) begin
        r.verdict = VERD_FULL;
      end else begin
        nbr_ip[nbr_count] = it.entry_ip;
        nbr_mac[nbr_count] = it.entry_mac;
        nbr_count++;
        r.verdict = VERD_STORED;
      end
    end else if (it.frame_type != ETYPE_IPV4) begin
      r.verdict = VERD_NOT_IPV4;
    end else if (it.ingress > 2'd1) begin
      r.verdict = VERD_BAD_IN;
    end else if (it.dst_mac != port_mac[it.ingress[0]]) begin
      r.verdict = VERD_WRONG_MAC;
    end else if (it.dest_ip == port_ip[0] || it.dest_ip == port_ip[1]) begin
      r.verdict = VERD_LOCAL;
    end else if (it.ttl <= 8'd1) begin
      r.verdict = VERD_TTL;
    end else begin
      m0 = subnet_mask(port_pfx[0]);
      m1 = subnet_mask(port_pfx[1]);
      hit0 = (it.dest_ip & m0) == (port_ip[0] & m0);
      hit1 = (it.dest_ip & m1) == (port_ip[1] & m1);
      l0 = (port_pfx[0] > 32) ? 32 : port_pfx[0];
      l1 = (port_pfx[1] > 32) ? 32 : port_pfx[1];
      if (hit0 && hit1) route = (l1 > l0) ? 1 : 0;
      else if (hit0) route = 0;
      else if (hit1) route = 1;
      else route = ROUTE_NONE;
      if (route == ROUTE_NONE) begin
        r.verdict = VERD_NO_ROUTE;
      end else if (route == it.ingress) begin
        r.verdict = VERD_SAME_PORT;
      end else if (!find_nbr(it.dest_ip, idx)) begin
        r.verdict = VERD_NO_NEIGH;
      end else begin
        r.verdict = VERD_FWD;
        r.egress = route[0];
        r.dst_mac = nbr_mac[idx];
        r.src_mac = port_mac[route];
        r.hop = it.ttl - 8'd1;
      end
    end
    return r;
  endfunction

  function automatic fwd_item_t mk_frame(input logic [15:0] et, input logic [1:0] ing,
                                         input logic [47:0] dmac, input logic [31:0] dip,
                                         input logic [7:0] ttl);
    fwd_item_t it;
    it.action = 1'b0;
    it.frame_type = et;
    it.ingress = ing;
    it.dst_mac = dmac;
    it.dest_ip = dip;
    it.ttl = ttl;
    it.entry_ip = $urandom;
    it.entry_mac = rand48();
    return it;
  endfunction

  function automatic fwd_item_t mk_add(input logic [31:0] ip, input logic [47:0] mac);
    fwd_item_t it;
    it = mk_frame(16'($urandom), 2'($urandom), rand48(), $urandom, 8'($urandom));
    it.action = 1'b1;
    it.entry_ip = ip;
    it.entry_mac = mac;
    return it;
  endfunction

  task automatic send_beat(input fwd_item_t it);
    int gap;
    gap = no_idle ? 0 : gap_len();
    @(negedge clk);
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser <= it.action;
    in_tdata <= {6'b0, it.entry_mac, it.entry_ip, it.ttl, it.dest_ip, it.dst_mac,
                 it.ingress, it.frame_type};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    pending_q.push_back(forward_decision(it));
    beats_sent++;
  endtask

  task automatic wait_results_done();
    @(negedge clk);
    in_tvalid <= 1'b0;
    while (pending_q.size() != 0) @(posedge clk);
    repeat (NEIGHBOUR_ENTRIES + 4) @(posedge clk);
  endtask

  task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_addr <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    cfg_writes++;
    case (idx)
      CFG_PORT0_MAC:    port_mac[0] = val;
      CFG_PORT0_IP:     port_ip[0] = val[31:0];
      CFG_PORT0_PREFIX: port_pfx[0] = val[5:0];
      CFG_PORT1_MAC:    port_mac[1] = val;
      CFG_PORT1_IP:     port_ip[1] = val[31:0];
      CFG_PORT1_PREFIX: port_pfx[1] = val[5:0];
      default: ;
    endcase
  endtask

  // all six registers, junk above the used bits, then the two unused indexes
  task automatic set_ports(input logic [47:0] mac0, input logic [31:0] ip0,
                           input logic [5:0] pfx0, input logic [47:0] mac1,
                           input logic [31:0] ip1, input logic [5:0] pfx1);
    wait_results_done();
    cfg_write(CFG_PORT0_MAC, mac0);
    cfg_write(CFG_PORT0_IP, {16'($urandom), ip0});
    cfg_write(CFG_PORT0_PREFIX, {42'(rand48()), pfx0});
    cfg_write(CFG_PORT1_MAC, mac1);
    cfg_write(CFG_PORT1_IP, {16'($urandom), ip1});
    cfg_write(CFG_PORT1_PREFIX, {42'(rand48()), pfx1});
    cfg_write(CFG_IDX_SPARE_LO, rand48());
    cfg_write(CFG_IDX_SPARE_HI, '1);
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  // all-zero settings straight after reset
  task automatic test_reset_defaults();
    send_beat(mk_frame(ETYPE_IPV4, 2'd0, 48'h0, 32'h0, 8'd64));
    send_beat(mk_frame(ETYPE_IPV4, 2'd0, 48'h0, 32'hC0A8_0101, 8'd64));
    send_beat(mk_frame(ETYPE_IPV4, 2'd1, 48'h0, 32'hFFFF_FFFF, 8'd64));
  endtask

  task automatic test_header_checks();
    logic [47:0] m0, m1;
    m0 = 48'hFFFF_FFFF_FFFF;
    m1 = 48'h0200_0000_0001;
    set_ports(m0, 32'h0A00_0001, 6'd16, m1, 32'h0A01_0001, 6'd16);
    send_beat(mk_frame(16'h86DD, 2'd0, m0, 32'h0A01_0005, 8'd64));
    send_beat(mk_frame(16'hFFFF, 2'd0, m0, 32'h0A01_0005, 8'd64));
    send_beat(mk_frame(16'h0000, 2'd1, m1, 32'h0A00_0009, 8'd64));
    send_beat(mk_frame(ETYPE_IPV4, 2'd2, m0, 32'h0A01_0005, 8'd64));
    send_beat(mk_frame(ETYPE_IPV4, 2'd3, m1, 32'h0A01_0005, 8'd64));
    send_beat(mk_frame(ETYPE_IPV4, 2'd0, m1, 32'h0A01_0005, 8'd64));
    send_beat(mk_frame(ETYPE_IPV4, 2'd1, 48'h0, 32'h0A00_0009, 8'd64));
    send_beat(mk_frame(ETYPE_IPV4, 2'd0, m0, 32'h0A00_0001, 8'd64));
    // local wins over an expiring ttl
    send_beat(mk_frame(ETYPE_IPV4, 2'd1, m1, 32'h0A01_0001, 8'd1));
    send_beat(mk_frame(ETYPE_IPV4, 2'd0, m0, 32'h0A01_0005, 8'd0));
    send_beat(mk_frame(ETYPE_IPV4, 2'd0, m0, 32'h0A01_0005, 8'd1));
    send_beat(mk_frame(ETYPE_IPV4, 2'd0, m0, 32'hC0A8_0001, 8'd64));
    send_beat(mk_frame(ETYPE_IPV4, 2'd1, m1, 32'h0A01_0203, 8'd64));
    send_beat(mk_frame(ETYPE_IPV4, 2'd0, m0, 32'h0A01_0005, 8'd64));
    send_beat(mk_add(32'h0A01_0005, 48'hFFFF_FFFF_FFFF));
    send_beat(mk_frame(ETYPE_IPV4, 2'd0, m0, 32'h0A01_0005, 8'd255));
    send_beat(mk_frame(ETYPE_IPV4, 2'd0, m0, 32'h0A01_0005, 8'd2));
    // same ip again overwrites the mac
    send_beat(mk_add(32'h0A01_0005, 48'h0));
    send_beat(mk_frame(ETYPE_IPV4, 2'd0, m0, 32'h0A01_0005, 8'd100));
    send_beat(mk_add(32'h0A00_0009, rand48()));
    send_beat(mk_frame(ETYPE_IPV4, 2'd1, m1, 32'h0A00_0009, 8'd128));
    send_beat(mk_add(32'h0, rand48()));
    send_beat(mk_add(32'hFFFF_FFFF, rand48()));
    send_beat(mk_frame(ETYPE_IPV4, 2'd1, m1, 32'h0, 8'd64));
    send_beat(mk_frame(ETYPE_IPV4, 2'd0, m0, 32'hFFFF_FFFF, 8'd64));
  endtask

  task automatic test_route_select();
    logic [47:0] m0, m1;
    m0 = rand48();
    m1 = rand48();
    // overlapping subnets, longer prefix wins
    set_ports(m0, 32'h0A00_0001, 6'd8, m1, 32'h0A01_0001, 6'd16);
    send_beat(mk_frame(ETYPE_IPV4, 2'd0, m0, 32'h0A01_0005, 8'd64));
    send_beat(mk_frame(ETYPE_IPV4, 2'd1, m1, 32'h0A00_0009, 8'd64));
    send_beat(mk_frame(ETYPE_IPV4, 2'd1, m1, 32'h0A02_0001, 8'd64));
    // equal prefixes, interface zero wins
    set_ports(m0, 32'h0A01_0001, 6'd16, m1, 32'h0A01_0002, 6'd16);
    send_beat(mk_frame(ETYPE_IPV4, 2'd1, m1, 32'h0A01_0005, 8'd64));
    send_beat(mk_frame(ETYPE_IPV4, 2'd0, m0, 32'h0A01_0005, 8'd64));
    // prefix above 32 acts as a host route
    set_ports(m0, 32'h0A00_0001, 6'd40, m1, 32'h0A01_0001, 6'd32);
    send_beat(mk_frame(ETYPE_IPV4, 2'd1, m1, 32'h0A00_0009, 8'd64));
    send_beat(mk_frame(ETYPE_IPV4, 2'd0, m0, 32'h0A01_0005, 8'd64));
    // prefix zero matches everything
    set_ports(m0, 32'h0A00_0001, 6'd0, m1, 32'h0A01_0001, 6'd63);
    send_beat(mk_frame(ETYPE_IPV4, 2'd1, m1, 32'h0A01_0005, 8'd64));
    send_beat(mk_frame(ETYPE_IPV4, 2'd1, m1, 32'h0A00_0009, 8'd3));
    send_beat(mk_frame(ETYPE_IPV4, 2'd0, m0, 32'h0A01_0005, 8'd64));
  endtask

  task automatic test_table_full();
    logic [31:0] ip;
    while (nbr_count < NEIGHBOUR_ENTRIES) begin
      ip = {15'h0500, 1'($urandom), 16'($urandom)};
      send_beat(mk_add(ip, rand48()));
    end
    send_beat(mk_add(32'hC0A8_0A0A, rand48()));
    send_beat(mk_add(nbr_ip[0], rand48()));
    send_beat(mk_add(nbr_ip[NEIGHBOUR_ENTRIES - 1], rand48()));
  endtask

  task automatic test_random_phase(input int count);
    fwd_item_t   it;
    int          sel, d;
    logic [31:0] ip, dip;
    logic [1:0]  ing;
    logic [15:0] et;
    logic [47:0] dmac;
    logic [7:0]  ttl;
    for (int n = 0; n < count; n++) begin
      sel = $urandom_range(0, 99);
      if (sel < 15) begin
        if (nbr_count != 0 && $urandom_range(0, 3) != 0)
          ip = nbr_ip[$urandom_range(0, nbr_count - 1)];
        else
          ip = $urandom;
        it = mk_add(ip, rand48());
      end else begin
        ing = ($urandom_range(0, 19) == 0) ? 2'($urandom_range(2, 3)) : 2'($urandom_range(0, 1));
        et = ($urandom_range(0, 14) == 0) ? 16'($urandom) : ETYPE_IPV4;
        dmac = ($urandom_range(0, 9) == 0) ? rand48() : port_mac[ing[0]];
        d = $urandom_range(0, 19);
        if (d < 11 && nbr_count != 0)
          dip = nbr_ip[$urandom_range(0, nbr_count - 1)];
        else if (d < 13)
          dip = port_ip[$urandom_range(0, 1)];
        else if (d < 16 && nbr_count != 0)
          dip = nbr_ip[$urandom_range(0, nbr_count - 1)] ^ (32'h1 << $urandom_range(0, 31));
        else
          dip = $urandom;
        ttl = ($urandom_range(0, 9) == 0) ? 8'($urandom_range(0, 1)) : 8'($urandom_range(2, 255));
        it = mk_frame(et, ing, dmac, dip, ttl);
      end
      send_beat(it);
    end
  endtask

  task automatic test_random();
    set_ports(rand48(), 32'h0A00_0001, 6'd16, rand48(), 32'h0A01_0001, 6'd16);
    test_random_phase(225);
    set_ports(48'h0, 32'h0A00_0001, 6'd8, 48'hFFFF_FFFF_FFFF, 32'h0A01_0001, 6'd16);
    no_idle = 1'b1;
    test_random_phase(225);
    no_idle = 1'b0;
    set_ports(rand48(), 32'h0A00_0001, 6'd0, rand48(), 32'h0A01_0001, 6'd32);
    test_random_phase(225);
    set_ports(rand48(), 32'h0, 6'($urandom_range(0, 4)), rand48(), 32'hFFFF_FFFF,
              6'($urandom_range(0, 63)));
    test_random_phase(225);
  endtask

  // result side stalls
  always @(negedge clk) begin
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else if (rx_hold != 0) begin
      out_tready <= 1'b0;
      rx_hold <= rx_hold - 1;
    end else begin
      out_tready <= 1'b1;
      if (!no_idle && $urandom_range(0, 3) == 0) rx_hold <= gap_len();
    end
  end

  always @(posedge clk) begin
    fwd_result_t want;
    if (rst_n && out_tvalid && out_tready) begin
      results_seen++;
      if (pending_q.size() == 0) begin
        $error("result beat with nothing pending: verdict %0d", out_tuser);
        errors++;
      end else begin
        want = pending_q.pop_front();
        if (out_tuser !== want.verdict) begin
          $error("verdict: expected %0d, got %0d", want.verdict, out_tuser);
          errors++;
        end
        if (out_tdata[0] !== want.egress) begin
          $error("egress_port: expected %0d, got %0d", want.egress, out_tdata[0]);
          errors++;
        end
        if (out_tdata[48:1] !== want.dst_mac) begin
          $error("new_dst_mac: expected %h, got %h", want.dst_mac, out_tdata[48:1]);
          errors++;
        end
        if (out_tdata[96:49] !== want.src_mac) begin
          $error("new_src_mac: expected %h, got %h", want.src_mac, out_tdata[96:49]);
          errors++;
        end
        if (out_tdata[104:97] !== want.hop) begin
          $error("new_hop_limit: expected %0d, got %0d", want.hop, out_tdata[104:97]);
          errors++;
        end
        if (want.verdict == VERD_FWD) fwd_seen++;
      end
    end
  end

  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IDLE_LIMIT) begin
      $display("CHECK FAILED");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    port_mac[0] = '0;
    port_mac[1] = '0;
    port_ip[0] = '0;
    port_ip[1] = '0;
    port_pfx[0] = '0;
    port_pfx[1] = '0;
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    test_reset_defaults();
    test_header_checks();
    test_route_select();
    test_table_full();
    test_random();
    wait_results_done();
    $display("covered %0d beats and %0d results, %0d forwarded, %0d register writes",
             beats_sent, results_seen, fwd_seen, cfg_writes);
    $display("neighbour table held %0d entries, mismatches %0d", nbr_count, errors);
    if (errors == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

[sim.f]
+incdir+rtl
rtl/ipv4fw_pkg.sv
rtl/ipv4fw_nbr_mem.sv
rtl/ipv4fw_route.sv
rtl/ipv4_two_port_forwarder_unit.sv
dv/tb_ipv4_two_port_forwarder_unit.sv
